@@ src/sird_pkg.sv @@
// ----------------------------------------------------------------------------
// sird_pkg
// Shared constants, types and the digit-to-character lookup for the
// signed integer to radix digits converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sird_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_RADIX  = 16;
	localparam int SYM_BITS   = 8;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = $clog2(MAX_RADIX);
	localparam int REM_W      = DIGIT_W + 1;
	localparam int STEP_W     = $clog2(VALUE_BITS);
	localparam int IDX_W      = $clog2(VALUE_BITS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int ALPHA_W    = 64;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MINUS_SYMBOL = 2'd3;

	localparam logic [RADIX_W-1:0]  RADIX_RST        = 5'd10;
	localparam logic [ALPHA_W-1:0]  SYMBOLS_LOW_RST  = 64'h3736353433323130;
	localparam logic [ALPHA_W-1:0]  SYMBOLS_HIGH_RST = 64'h0000000000003938;
	localparam logic [SYM_BITS-1:0] MINUS_RST        = 8'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} sird_state_t;

	typedef struct packed {
		logic                  start;
		logic [REM_W-1:0]      base;
		logic [VALUE_BITS-1:0] dividend;
	} div_ctl_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic                  zero;
		logic [DIGIT_W-1:0]    digit;
		logic [VALUE_BITS-1:0] quotient;
	} div_stat_t;

	function automatic logic [SYM_BITS-1:0] digit_symbol(
		input logic [ALPHA_W-1:0] lo,
		input logic [ALPHA_W-1:0] hi,
		input logic [DIGIT_W-1:0] d
	);
		logic [2*ALPHA_W-1:0] alpha;
		alpha = {hi, lo};
		return alpha[{d, 3'b000} +: SYM_BITS];
	endfunction

endpackage

@@ src/sird_if.sv @@
// ----------------------------------------------------------------------------
// sird_in_if / sird_out_if
// Valid/ready channels for the input value and the output characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sird_in_if import sird_pkg::*;;
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sird_out_if import sird_pkg::*;;
	logic                valid;
	logic                ready;
	logic [SYM_BITS-1:0] symbol;
	logic                last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink   (input valid, input symbol, input last, output ready);
endinterface

@@ src/sird_serdiv.sv @@
// ----------------------------------------------------------------------------
// sird_serdiv
// Bit-serial restoring divider: one quotient bit per cycle, giving one digit
// (the remainder) and the quotient after VALUE_BITS steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sird_serdiv import sird_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_ctl_t  ctl,
	output div_stat_t stat
);

	logic [VALUE_BITS-1:0] quo_q;
	logic [REM_W-1:0]      rem_q;
	logic [REM_W-1:0]      base_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [REM_W-1:0] rem_shift;
	logic             ge;
	logic [REM_W-1:0] rem_next;

	// The partial remainder stays below the base, so shifting in one bit fits REM_W.
	assign rem_shift = {rem_q[REM_W-2:0], quo_q[VALUE_BITS-1]};
	assign ge        = rem_shift >= base_q;
	assign rem_next  = ge ? rem_shift - base_q : rem_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q  <= ctl.dividend;
			rem_q  <= '0;
			base_q <= ctl.base;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.zero     = (quo_q == '0);
	assign stat.digit    = rem_q[DIGIT_W-1:0];
	assign stat.quotient = quo_q;

endmodule

@@ src/signed_integer_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// Each digit takes one pass of the bit-serial divider (32 steps, then a handoff
// into the digit store), and all digits are stored before the first character
// is loaded. Characters then leave one per cycle from an output register while
// the output is ready; a new value is taken once the last character is loaded.
// Reset clears the control state and restores the default alphabet and radix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_integer_to_radix_digits import sird_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	sird_in_if.sink              din,
	sird_out_if.source           dout
);

	logic [RADIX_W-1:0]  radix_q;
	logic [ALPHA_W-1:0]  sym_lo_q;
	logic [ALPHA_W-1:0]  sym_hi_q;
	logic [SYM_BITS-1:0] minus_q;

	sird_state_t state_q, state_d;
	logic                neg_q;
	logic [CNT_W-1:0]    count_q;
	logic [DIGIT_W-1:0]  digits_q [VALUE_BITS];
	logic                out_valid_q;
	logic [SYM_BITS-1:0] out_symbol_q;
	logic                out_last_q;

	div_ctl_t  div_ctl;
	div_stat_t div_stat;

	logic                  accept;
	logic                  push;
	logic                  load_out;
	logic                  final_char;
	logic [VALUE_BITS-1:0] mag;
	logic [RADIX_W-1:0]    base;
	logic [IDX_W-1:0]      top_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RST;
			sym_lo_q <= SYMBOLS_LOW_RST;
			sym_hi_q <= SYMBOLS_HIGH_RST;
			minus_q  <= MINUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIX:        radix_q  <= cfg_wdata[RADIX_W-1:0];
				REG_SYMBOLS_LOW:  sym_lo_q <= cfg_wdata[ALPHA_W-1:0];
				REG_SYMBOLS_HIGH: sym_hi_q <= cfg_wdata[ALPHA_W-1:0];
				REG_MINUS_SYMBOL: minus_q  <= cfg_wdata[SYM_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign mag = din.value[VALUE_BITS-1] ? VALUE_BITS'(-din.value) : VALUE_BITS'(din.value);

	always_comb begin
		if (radix_q < RADIX_W'(2)) begin
			base = RADIX_W'(2);
		end else if (radix_q > RADIX_W'(MAX_RADIX)) begin
			base = RADIX_W'(MAX_RADIX);
		end else begin
			base = radix_q;
		end
	end

	assign top_idx    = IDX_W'(count_q - 1'b1);
	assign final_char = !neg_q && (count_q == CNT_W'(1));

	// Output and control strobes.
	always_comb begin
		din.ready = (state_q == ST_IDLE);
		accept    = din.valid && din.ready;
		push      = (state_q == ST_DIV) && div_stat.done;
		load_out  = (state_q == ST_EMIT) && (!out_valid_q || dout.ready);
		div_ctl.start    = accept || (push && !div_stat.zero);
		div_ctl.base     = REM_W'(base);
		div_ctl.dividend = accept ? mag : div_stat.quotient;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done && div_stat.zero) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load_out && final_char) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	sird_serdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				neg_q   <= din.value[VALUE_BITS-1];
				count_q <= '0;
			end else if (push) begin
				count_q <= count_q + 1'b1;
			end else if (load_out) begin
				if (neg_q) begin
					neg_q <= 1'b0;
				end else begin
					count_q <= count_q - 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Digits are gathered least significant first and popped from the top.
	always_ff @(posedge clk) begin
		if (push) begin
			digits_q[count_q[IDX_W-1:0]] <= div_stat.digit;
		end
		if (load_out) begin
			out_symbol_q <= neg_q ? minus_q : digit_symbol(sym_lo_q, sym_hi_q, digits_q[top_idx]);
			out_last_q   <= final_char;
		end
	end

	assign dout.valid  = out_valid_q;
	assign dout.symbol = out_symbol_q;
	assign dout.last   = out_last_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(VALUE_BITS))
		else $error("digit count exceeds the value width");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (count_q == '0))
		else $error("digits left over in idle");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (count_q != '0))
		else $error("emitting with no digits stored");

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_stat.busy)
		else $error("divider started while busy");
`endif

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for signed_integer_to_radix_digits. A scoreboard expands every
// accepted value into its expected character stream under the current radix,
// alphabet and minus character, and checks each output transfer against it.
// Directed values and register extremes come first, then random phases, each
// with a fresh register setting and, on each channel, random stalls or none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import sird_pkg::*;

	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int RANDOM_ITEMS = 500;

	typedef struct packed {
		logic [SYM_BITS-1:0] symbol;
		logic                last;
	} text_char_t;

	class radix_text_scoreboard;
		logic [RADIX_W-1:0]  radix_reg;
		logic [ALPHA_W-1:0]  alpha_lo;
		logic [ALPHA_W-1:0]  alpha_hi;
		logic [SYM_BITS-1:0] minus_sym;
		text_char_t          expected_chars[$];
		int                  errors;

		function new();
			radix_reg = RADIX_RST;
			alpha_lo  = SYMBOLS_LOW_RST;
			alpha_hi  = SYMBOLS_HIGH_RST;
			minus_sym = MINUS_RST;
			errors    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_RADIX:        radix_reg = data[RADIX_W-1:0];
				REG_SYMBOLS_LOW:  alpha_lo  = data;
				REG_SYMBOLS_HIGH: alpha_hi  = data;
				REG_MINUS_SYMBOL: minus_sym = data[SYM_BITS-1:0];
				default: ;
			endcase
		endfunction

		function int effective_radix();
			if (radix_reg < 2)
				return 2;
			if (radix_reg > MAX_RADIX)
				return MAX_RADIX;
			return radix_reg;
		endfunction

		// Remainders come out least significant first; they are emitted from the
		// back of the list so the text reads most significant digit first.
		function void note_value(logic signed [VALUE_BITS-1:0] v);
			logic [VALUE_BITS-1:0] mag;
			logic [VALUE_BITS-1:0] base;
			int                    digits[$];
			int                    d;
			text_char_t            c;
			mag  = v[VALUE_BITS-1] ? ~v + 1'b1 : v;
			base = effective_radix();
			if (mag == 0)
				digits.push_back(0);
			while (mag != 0) begin
				digits.push_back(int'(mag % base));
				mag = mag / base;
			end
			if (v[VALUE_BITS-1]) begin
				c.symbol = minus_sym;
				c.last   = 1'b0;
				expected_chars.push_back(c);
			end
			for (int k = digits.size() - 1; k >= 0; k--) begin
				d        = digits[k];
				c.symbol = (d < 8) ? alpha_lo[8*d +: 8] : alpha_hi[8*(d-8) +: 8];
				c.last   = (k == 0);
				expected_chars.push_back(c);
			end
		endfunction

		function void check_char(logic [SYM_BITS-1:0] symbol, logic last);
			text_char_t want;
			if (expected_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected character: expected none, got symbol %h last %b",
					$time, symbol, last);
				return;
			end
			want = expected_chars.pop_front();
			if (symbol !== want.symbol) begin
				errors++;
				$display("%0t: symbol mismatch: expected %h, got %h", $time, want.symbol, symbol);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: last mismatch: expected %b, got %b", $time, want.last, last);
			end
		endfunction

		function int pending_count();
			return expected_chars.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	sird_in_if  in_ch ();
	sird_out_if out_ch ();

	signed_integer_to_radix_digits dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.din       (in_ch),
		.dout      (out_ch)
	);

	radix_text_scoreboard sb = new();
	int                   items_sent;
	int                   cycle_count;
	bit                   in_steady;
	bit                   out_steady;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
		int gap;
		gap = in_steady ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.value = v;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_value(v);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic wait_drained();
		in_ch.valid = 1'b0;
		while (sb.pending_count() != 0)
			@(negedge clk);
	endtask

	// Unused upper bits of the narrow registers get random data as well.
	task automatic configure(input logic [RADIX_W-1:0] radix, input logic [ALPHA_W-1:0] lo,
			input logic [ALPHA_W-1:0] hi, input logic [SYM_BITS-1:0] minus);
		logic [CFG_W-1:0] data;
		wait_drained();
		data = {$urandom, $urandom};
		data[RADIX_W-1:0] = radix;
		write_reg(REG_RADIX, data);
		write_reg(REG_SYMBOLS_LOW, lo);
		write_reg(REG_SYMBOLS_HIGH, hi);
		data = {$urandom, $urandom};
		data[SYM_BITS-1:0] = minus;
		write_reg(REG_MINUS_SYMBOL, data);
		in_steady  = ($urandom_range(0, 3) == 0);
		out_steady = ($urandom_range(0, 3) == 0);
	endtask

	function automatic logic signed [VALUE_BITS-1:0] random_value();
		logic [VALUE_BITS-1:0] v;
		longint unsigned       p;
		int                    b;
		b = sb.effective_radix();
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 300);
			3: begin
				// Near a power of the radix, where the digit count changes.
				p = 1;
				repeat ($urandom_range(1, 31))
					if (p * b <= 64'h8000_0000)
						p = p * b;
				v = p[VALUE_BITS-1:0] - $urandom_range(0, 1);
			end
			4: v = $urandom >> $urandom_range(1, 31);
			default: begin
				case ($urandom_range(0, 3))
					0: v = 32'h0000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h8000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// The output side draws a new stall before every character unless the phase runs steady.
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = out_steady ? 0 : $urandom_range(0, 10);
			if (gap != 0) begin
				out_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			sb.check_char(out_ch.symbol, out_ch.last);
			@(negedge clk);
		end
	end

	initial begin
		logic [RADIX_W-1:0] r;
		logic [ALPHA_W-1:0] lo;
		logic [ALPHA_W-1:0] hi;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_RADIX;
		cfg_wdata   = '0;
		in_ch.valid = 1'b0;
		in_ch.value = '0;
		items_sent  = 0;
		cycle_count = 0;
		in_steady   = 1'b0;
		out_steady  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: decimal with the standard characters.
		send_value(0);
		send_value(1);
		send_value(-1);
		send_value(32'sh7FFF_FFFF);
		send_value(32'sh8000_0000);
		send_value(9);
		send_value(10);
		send_value(-10);
		send_value(100);

		// A radix of zero or one behaves as binary.
		configure(5'd0, SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST, MINUS_RST);
		send_value(-1);
		send_value(32'sh7FFF_FFFF);
		send_value(32'sh8000_0000);
		configure(5'd1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		send_value(0);
		send_value(-5);

		// Anything above sixteen behaves as sixteen.
		configure(5'd31, SYMBOLS_LOW_RST, 64'h4645_4443_4241_3938, MINUS_RST);
		send_value(32'sh8000_0000);
		send_value(32'sh7EDC_BA98);
		send_value(-16);
		configure(5'd17, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'h00);
		send_value(255);
		send_value(-256);
		configure(5'd16, SYMBOLS_LOW_RST, 64'h4645_4443_4241_3938, MINUS_RST);
		send_value(32'shFEDC_BA98);
		send_value(32'sh0123_4567);
		configure(5'd3, SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST, MINUS_RST);
		send_value(-32'sd2147483647);

		while (items_sent < RANDOM_ITEMS + 22) begin
			if ($urandom_range(0, 9) == 0)
				r = ($urandom_range(0, 1) == 0) ? RADIX_W'($urandom_range(0, 1)) :
					RADIX_W'($urandom_range(17, 31));
			else
				r = RADIX_W'($urandom_range(2, 16));
			if ($urandom_range(0, 2) == 0) begin
				lo = SYMBOLS_LOW_RST;
				hi = 64'h4645_4443_4241_3938;
			end else begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end
			configure(r, lo, hi, SYM_BITS'($urandom));
			repeat ($urandom_range(15, 50))
				send_value(random_value());
		end

		wait_drained();
		repeat (80) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
